/* sv/rps_pkg.sv */
// rps_pkg: widths, codes and constant tables for the ramped phasor source.
// Used by the CORDIC cell and the top level; depends on nothing.
`default_nettype none

package rps_pkg;

  localparam int CORDIC_STAGES_DEF = 20;
  localparam int QUO_W = 32;          // quotient bits of the ramp fraction
  localparam int XW    = 36;          // CORDIC vector datapath width
  localparam int ZW    = 34;          // CORDIC residual angle width

  // item classes travelling down the pipe
  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_RAMP = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;

  // quadrant codes, top two angle bits
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // register indexes
  localparam logic [2:0] REG_REF_REAL    = 3'd0;
  localparam logic [2:0] REG_REF_IMAG    = 3'd1;
  localparam logic [2:0] REG_STEP_REAL   = 3'd2;
  localparam logic [2:0] REG_STEP_IMAG   = 3'd3;
  localparam logic [2:0] REG_FREQ_OFFSET = 3'd4;
  localparam logic [2:0] REG_SWITCH_TICK = 3'd5;
  localparam logic [2:0] REG_RAMP_TICKS  = 3'd6;

  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
  // (2^22 * INV_GAIN) >> 24: pre-scaled unit vector for the fade cosine
  localparam logic signed [XW-1:0] FADE_X0 = 36'sh026DD3B6A;
  localparam logic signed [XW-1:0] ONE_Q30 = 36'sd1073741824;
  localparam logic signed [XW-1:0] MONE_Q30 = -36'sd1073741824;
  localparam logic signed [XW:0] OUT_MAX = 37'sd8388607;
  localparam logic signed [XW:0] OUT_MIN = -37'sd8388608;

  // atan(2^-i) in Q32 turns
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      24: v = 32'h00000028;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000002;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/rps_div_cell.sv */
// rps_div_cell: one restoring-division step, one quotient bit per cell.
// Stand-alone; the divisor is the static ramp length register.
`default_nettype none

module rps_div_cell #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [31:0]   ramp,
  input  logic          vld_in,
  input  logic [31:0]   rem_in,
  input  logic [31:0]   quo_in,
  input  logic [SW-1:0] side_in,
  output logic          vld_out,
  output logic [31:0]   rem_out,
  output logic [31:0]   quo_out,
  output logic [SW-1:0] side_out
);

  logic [32:0] dbl;
  logic [32:0] diff;
  logic        ge;

  assign dbl  = {rem_in, 1'b0};
  assign diff = dbl - {1'b0, ramp};
  assign ge   = dbl >= {1'b0, ramp};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? diff[31:0] : dbl[31:0];
      quo_out  <= {quo_in[30:0], ge};
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

/* sv/rps_cordic_cell.sv */
// rps_cordic_cell: one CORDIC micro-rotation with floor shifts.
// Depends on rps_pkg for widths and the arctangent table.
`default_nettype none

module rps_cordic_cell import rps_pkg::*; #(
  parameter int IDX = 0,
  parameter int SW  = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic [SW-1:0]        side_in,
  output logic                 vld_out,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic [SW-1:0]        side_out
);

  localparam logic signed [ZW-1:0] AT = $signed({{(ZW-32){1'b0}}, atan_turn(IDX)});

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      if (!z_in[ZW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - AT;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + AT;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/ramped_phasor_source_top.sv */
// ramped_phasor_source_top: time tick in, ramped and rotated voltage phasor out.
// Depends on rps_pkg, rps_div_cell and rps_cordic_cell.
//
// Usage
//   Input channel: in_valid/in_ready with time_tick; one transfer per tick value.
//   Output channel: out_valid/out_ready with volt_real/volt_imag, one result
//   per input, in order.
//   Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; cfg_ready is
//   always high. Write only while no item is in flight.
// Pipeline
//   Each input transfer passes through 32 divider cells, two CORDIC chains
//   (fade cosine, then output rotation) of N cells each, N being
//   CORDIC_STAGES clamped to 32, and seven single registers before out_valid
//   rises. Throughput is one item per cycle while the pipe is not stalled.
// Stall
//   The whole pipe moves on one enable. It holds only when the last CORDIC
//   cell has a result and the output register is full and not taken, so new
//   items are taken while a result waits as long as the pipe end is empty.
// Reset
//   rst (synchronous) clears all valid flags and the config registers to 0.
`default_nettype none

module ramped_phasor_source_top import rps_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        time_tick,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] volt_real,
  output logic signed [23:0] volt_imag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int DSW = 64;          // divider side: prod[61:0], mode
  localparam int FSW = 114;         // fade side: prod, mode, pr, pi
  localparam logic signed [32:0] INV_S = {1'b0, INV_GAIN};

  // ---- configuration registers ----
  logic signed [23:0] ref_real;
  logic signed [23:0] ref_imag;
  logic signed [23:0] step_real;
  logic signed [23:0] step_imag;
  logic signed [31:0] freq_offset;
  logic [31:0]        switch_tick;
  logic [31:0]        ramp_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_real    <= '0;
      ref_imag    <= '0;
      step_real   <= '0;
      step_imag   <= '0;
      freq_offset <= '0;
      switch_tick <= '0;
      ramp_ticks  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REF_REAL:    ref_real    <= cfg_data[23:0];
        REG_REF_IMAG:    ref_imag    <= cfg_data[23:0];
        REG_STEP_REAL:   step_real   <= cfg_data[23:0];
        REG_STEP_IMAG:   step_imag   <= cfg_data[23:0];
        REG_FREQ_OFFSET: freq_offset <= cfg_data;
        REG_SWITCH_TICK: switch_tick <= cfg_data;
        REG_RAMP_TICKS:  ramp_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- pipe enable ----
  logic en;
  logic mvld_last;

  assign en       = !mvld_last || !out_valid || out_ready;
  assign in_ready = en;

  // ---- stage A: capture tick ----
  logic        a_vld;
  logic [31:0] a_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_t <= time_tick;
    end
  end

  // ---- stage B: classify, offset, frequency product ----
  logic [31:0]        b_d;
  logic signed [64:0] b_prod_full;
  logic [1:0]         b_mode;

  assign b_d         = a_t - switch_tick;
  assign b_prod_full = freq_offset * $signed({1'b0, a_t});

  always_comb begin
    if (a_t < switch_tick) begin
      b_mode = MODE_HOLD;
    end else if (b_d < ramp_ticks) begin
      b_mode = MODE_RAMP;
    end else begin
      b_mode = MODE_FULL;
    end
  end

  // divider chain: index 0 is the stage B register
  logic            dv_vld  [0:QUO_W];
  logic [31:0]     dv_rem  [0:QUO_W];
  logic [31:0]     dv_quo  [0:QUO_W];
  logic [DSW-1:0]  dv_side [0:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]  <= b_d;
      dv_side[0] <= {b_prod_full[61:0], b_mode};
    end
  end

  assign dv_quo[0] = '0;

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    rps_div_cell #(.SW(DSW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ramp     (ramp_ticks),
      .vld_in   (dv_vld[i]),
      .rem_in   (dv_rem[i]),
      .quo_in   (dv_quo[i]),
      .side_in  (dv_side[i]),
      .vld_out  (dv_vld[i+1]),
      .rem_out  (dv_rem[i+1]),
      .quo_out  (dv_quo[i+1]),
      .side_out (dv_side[i+1])
    );
  end

  // ---- stage C: ramped phasor and fade CORDIC entry ----
  logic [31:0]        xq;
  logic signed [56:0] mr;
  logic signed [56:0] mi;
  logic [24:0]        c_pr;
  logic [24:0]        c_pi;

  assign xq   = dv_quo[QUO_W];
  assign mr   = $signed({1'b0, xq}) * step_real;
  assign mi   = $signed({1'b0, xq}) * step_imag;
  assign c_pr = {ref_real[23], ref_real} + mr[56:32];
  assign c_pi = {ref_imag[23], ref_imag} + mi[56:32];

  logic                 fc_vld  [0:NST];
  logic signed [XW-1:0] fc_x    [0:NST];
  logic signed [XW-1:0] fc_y    [0:NST];
  logic signed [ZW-1:0] fc_z    [0:NST];
  logic [FSW-1:0]       fc_side [0:NST];

  // angle is xq/2 turns: top bit clear, quadrant 0 or 1
  assign fc_vld[0]  = dv_vld[QUO_W];
  assign fc_x[0]    = xq[31] ? '0 : FADE_X0;
  assign fc_y[0]    = xq[31] ? FADE_X0 : '0;
  assign fc_z[0]    = $signed({{(ZW-30){1'b0}}, xq[30:1]});
  assign fc_side[0] = {dv_side[QUO_W], c_pr, c_pi};

  for (genvar i = 0; i < NST; i++) begin : g_fade
    rps_cordic_cell #(.IDX(i), .SW(FSW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (fc_vld[i]),
      .x_in     (fc_x[i]),
      .y_in     (fc_y[i]),
      .z_in     (fc_z[i]),
      .side_in  (fc_side[i]),
      .vld_out  (fc_vld[i+1]),
      .x_out    (fc_x[i+1]),
      .y_out    (fc_y[i+1]),
      .z_out    (fc_z[i+1]),
      .side_out (fc_side[i+1])
    );
  end

  // ---- stage D: fade = (1 - cos) / 2 in Q30 ----
  logic signed [XW-1:0] cc;
  logic signed [XW-1:0] dif;
  logic                 d_vld;
  logic [30:0]          d_fade;
  logic [FSW-1:0]       d_side;

  always_comb begin
    if (fc_x[NST] > ONE_Q30) begin
      cc = ONE_Q30;
    end else if (fc_x[NST] < MONE_Q30) begin
      cc = MONE_Q30;
    end else begin
      cc = fc_x[NST];
    end
  end

  assign dif = ONE_Q30 - cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= fc_vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_fade <= dif[31:1];
      d_side <= fc_side[NST];
    end
  end

  // side layout: [113:52] prod, [51:50] mode, [49:25] pr, [24:0] pi
  logic [61:0] d_prod;
  assign d_prod = d_side[113:52];

  // ---- stage E: fade * product, split in two partial products ----
  logic [61:0]  e_mlo_c;
  logic [61:0]  e_mhi_c;
  logic         e_vld;
  logic [61:0]  e_mlo;
  logic [30:0]  e_mhi;
  logic [31:0]  e_prod;
  logic [51:0]  e_rest;

  assign e_mlo_c = d_fade * d_prod[30:0];
  assign e_mhi_c = d_fade * d_prod[61:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_mlo  <= e_mlo_c;
      e_mhi  <= e_mhi_c[30:0];
      e_prod <= d_prod[31:0];
      e_rest <= d_side[51:0];
    end
  end

  // ---- stage F: angle and rotation operand select ----
  logic [61:0]        f_sum;
  logic [1:0]         e_mode;
  logic               f_vld;
  logic signed [24:0] f_vx;
  logic signed [24:0] f_vy;
  logic [31:0]        f_ang;
  logic [1:0]         f_mode;

  assign f_sum  = e_mlo + {e_mhi, 31'b0};
  assign e_mode = e_rest[51:50];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_mode <= e_mode;
      if (e_mode == MODE_RAMP) begin
        f_vx  <= e_rest[49:25];
        f_vy  <= e_rest[24:0];
        f_ang <= f_sum[61:30];
      end else begin
        f_vx  <= {ref_real[23], ref_real} + {step_real[23], step_real};
        f_vy  <= {ref_imag[23], ref_imag} + {step_imag[23], step_imag};
        f_ang <= e_prod;
      end
    end
  end

  // ---- stage G: inverse gain pre-scale ----
  logic signed [57:0]   px;
  logic signed [57:0]   py;
  logic                 g_vld;
  logic signed [XW-1:0] g_x;
  logic signed [XW-1:0] g_y;
  logic [31:0]          g_ang;
  logic [1:0]           g_mode;

  assign px = f_vx * INV_S;
  assign py = f_vy * INV_S;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_x    <= {{(XW-34){px[57]}}, px[57:24]};
      g_y    <= {{(XW-34){py[57]}}, py[57:24]};
      g_ang  <= f_ang;
      g_mode <= f_mode;
    end
  end

  // ---- output rotation chain, quadrant folded into its entry ----
  logic                 mc_vld  [0:NST];
  logic signed [XW-1:0] mc_x    [0:NST];
  logic signed [XW-1:0] mc_y    [0:NST];
  logic signed [ZW-1:0] mc_z    [0:NST];
  logic [1:0]           mc_side [0:NST];

  always_comb begin
    case (g_ang[31:30])
      QUAD_1: begin
        mc_x[0] = -g_y;
        mc_y[0] = g_x;
      end
      QUAD_2: begin
        mc_x[0] = -g_x;
        mc_y[0] = -g_y;
      end
      QUAD_3: begin
        mc_x[0] = g_y;
        mc_y[0] = -g_x;
      end
      default: begin
        mc_x[0] = g_x;
        mc_y[0] = g_y;
      end
    endcase
  end

  assign mc_vld[0]  = g_vld;
  assign mc_z[0]    = $signed({{(ZW-30){1'b0}}, g_ang[29:0]});
  assign mc_side[0] = g_mode;

  for (genvar i = 0; i < NST; i++) begin : g_main
    rps_cordic_cell #(.IDX(i), .SW(2)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (mc_vld[i]),
      .x_in     (mc_x[i]),
      .y_in     (mc_y[i]),
      .z_in     (mc_z[i]),
      .side_in  (mc_side[i]),
      .vld_out  (mc_vld[i+1]),
      .x_out    (mc_x[i+1]),
      .y_out    (mc_y[i+1]),
      .z_out    (mc_z[i+1]),
      .side_out (mc_side[i+1])
    );
  end

  assign mvld_last = mc_vld[NST];

  // ---- output register: round, saturate, or pass the reference ----
  function automatic logic signed [23:0] finish(input logic signed [XW-1:0] v);
    logic signed [XW:0] s;
    logic signed [XW:0] r;
    logic signed [23:0] o;
    s = {v[XW-1], v} + (XW+1)'(128);
    r = s >>> 8;
    if (r > OUT_MAX) begin
      o = OUT_MAX[23:0];
    end else if (r < OUT_MIN) begin
      o = OUT_MIN[23:0];
    end else begin
      o = r[23:0];
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && mvld_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && mvld_last) begin
      if (mc_side[NST] == MODE_HOLD) begin
        volt_real <= ref_real;
        volt_imag <= ref_imag;
      end else begin
        volt_real <= finish(mc_x[NST]);
        volt_imag <= finish(mc_y[NST]);
      end
    end
  end

endmodule

`default_nettype wire
